@@ design/speed_pi_loop_with_lowpass_unit_macros.svh @@
// Assertion macros for the speed PI loop unit.
// Used by the port checker; needs a clock and an active-low reset in scope.
`ifndef SPEED_PI_LOOP_WITH_LOWPASS_UNIT_MACROS_SVH
`define SPEED_PI_LOOP_WITH_LOWPASS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spl assertion failed");

// Next-cycle implication, disabled during reset
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spl assertion failed");

`endif

@@ design/spl_pkg.sv @@
// Shared types and constants of the speed PI loop unit.
// No dependencies; imported by the controller, datapath and top level.
package spl_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPEED_GAIN     = 3'd0,
    CFG_INTEGRAL_GAIN  = 3'd1,
    CFG_FILTER_ALPHA   = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_TILT_LIMIT     = 3'd4
  } spl_cfg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 24;

  // Register reset values
  localparam logic signed [23:0] SPEED_GAIN_RST     = -24'sd241664;
  localparam logic signed [23:0] INTEGRAL_GAIN_RST  = -24'sd808;
  localparam logic        [7:0]  FILTER_ALPHA_RST   = 8'd179;
  localparam logic        [19:0] INTEGRAL_LIMIT_RST = 20'd10000;
  localparam logic        [15:0] TILT_LIMIT_RST     = 16'd10240;

  // Operand pair of the shared multiplier
  typedef enum logic [1:0] {
    MUL_ERR_ALPHA = 2'd0,
    MUL_FS_ALPHA  = 2'd1,
    MUL_KP_FILT   = 2'd2,
    MUL_KI_INTEG  = 2'd3
  } spl_mul_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic         capture;
    spl_mul_sel_e mul_sel;
    logic         acc_load;
    logic         acc_add;
    logic         filt_en;
    logic         integ_en;
    logic         out_load;
  } spl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } spl_status_t;

endpackage

@@ design/spl_if.sv @@
// Valid/ready channel interfaces of the speed PI loop unit.
// Input item: wheel speeds and pitch; result item: drive, filter and integrator.
interface spl_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  left_speed;
  logic signed [15:0]  right_speed;
  logic signed [16:0]  pitch_angle;

  modport source (output valid, output left_speed, output right_speed,
                  output pitch_angle, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input pitch_angle, output ready);
endinterface

interface spl_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  drive_value;
  logic signed [16:0]  filtered_error;
  logic signed [20:0]  integral_sum;

  modport source (output valid, output drive_value, output filtered_error,
                  output integral_sum, input ready);
  modport sink   (input valid, input drive_value, input filtered_error,
                  input integral_sum, output ready);
endinterface

@@ design/spl_ctrl.sv @@
// Sequencer of the speed PI loop unit.
// Depends on spl_pkg; drives the datapath through spl_cmd_t.
module spl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spl_pkg::spl_status_t status_i,
  output spl_pkg::spl_cmd_t    cmd_o
);
  import spl_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL_E  = 9'b000000010,
    ST_MUL_F  = 9'b000000100,
    ST_SUM_F  = 9'b000001000,
    ST_FILT   = 9'b000010000,
    ST_INTEG  = 9'b000100000,
    ST_MUL_KI = 9'b001000000,
    ST_SUM_D  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } spl_state_e;

  spl_state_e state_q, state_d;
  logic       accept;

  // Take an item when idle, or when the finished result can be loaded now
  assign in_ready_o = (state_q == ST_IDLE) ||
                      ((state_q == ST_DONE) && !status_i.out_busy);
  assign accept     = in_ready_o && in_valid_i;

  // Decode commands and next state
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_ERR_ALPHA;
    cmd_o.capture    = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd_o.mul_sel = MUL_ERR_ALPHA;
        state_d       = ST_MUL_F;
      end
      ST_MUL_F: begin
        cmd_o.mul_sel  = MUL_FS_ALPHA;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_SUM_F;
      end
      ST_SUM_F: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.filt_en = 1'b1;
        state_d       = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.integ_en = 1'b1;
        cmd_o.mul_sel  = MUL_KP_FILT;
        state_d        = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd_o.mul_sel  = MUL_KI_INTEG;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_SUM_D;
      end
      ST_SUM_D: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = accept ? ST_MUL_E : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/spl_datapath.sv @@
// Datapath of the speed PI loop unit: registers, shared multiplier, filter,
// integrator and output register. Depends on spl_pkg; driven by spl_ctrl.
module spl_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spl_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [spl_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic signed [15:0]             left_speed_i,
  input  logic signed [15:0]             right_speed_i,
  input  logic signed [16:0]             pitch_angle_i,
  input  spl_pkg::spl_cmd_t              cmd_i,
  output spl_pkg::spl_status_t           status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [31:0]             drive_value_o,
  output logic signed [16:0]             filtered_error_o,
  output logic signed [20:0]             integral_sum_o
);
  import spl_pkg::*;

  logic signed [23:0] speed_gain_q, integral_gain_q;
  logic        [7:0]  filter_alpha_q;
  logic        [19:0] integral_limit_q;
  logic        [15:0] tilt_limit_q;

  logic signed [16:0] err_q, pitch_q, filt_q, filt_d;
  logic signed [20:0] integ_q, integ_d;
  logic signed [24:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [46:0] prod_d, prod_q, acc_q;
  logic        [8:0]  alpha_inv;

  logic signed [26:0] fsum, fbias;
  logic signed [21:0] isum, ilim, iclamp;
  logic signed [17:0] pitch_x, tilt_x;
  logic signed [46:0] dbias;
  logic signed [34:0] dquo;
  logic signed [31:0] drive_d;

  logic               out_valid_q;
  logic signed [31:0] drive_q;
  logic signed [16:0] filt_out_q;
  logic signed [20:0] integ_out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_gain_q     <= SPEED_GAIN_RST;
      integral_gain_q  <= INTEGRAL_GAIN_RST;
      filter_alpha_q   <= FILTER_ALPHA_RST;
      integral_limit_q <= INTEGRAL_LIMIT_RST;
      tilt_limit_q     <= TILT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPEED_GAIN:     speed_gain_q     <= $signed(cfg_wdata_i);
        CFG_INTEGRAL_GAIN:  integral_gain_q  <= $signed(cfg_wdata_i);
        CFG_FILTER_ALPHA:   filter_alpha_q   <= cfg_wdata_i[7:0];
        CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata_i[19:0];
        CFG_TILT_LIMIT:     tilt_limit_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Capture speed error and pitch of the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      err_q   <= 17'(left_speed_i) + 17'(right_speed_i);
      pitch_q <= pitch_angle_i;
    end
  end

  // Select multiplier operands
  assign alpha_inv = 9'd256 - {1'b0, filter_alpha_q};
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_ALPHA: begin
        mul_a = $signed({16'd0, alpha_inv});
        mul_b = 22'(err_q);
      end
      MUL_FS_ALPHA: begin
        mul_a = $signed({17'd0, filter_alpha_q});
        mul_b = 22'(filt_q);
      end
      MUL_KP_FILT: begin
        mul_a = 25'(speed_gain_q);
        mul_b = 22'(filt_q);
      end
      MUL_KI_INTEG: begin
        mul_a = 25'(integral_gain_q);
        mul_b = 22'(integ_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // Register product, load or add into the accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Divide the filter sum by 256, truncating toward zero
  assign fsum   = acc_q[26:0];
  assign fbias  = fsum + $signed({19'd0, {8{fsum[26]}}});
  assign filt_d = fbias[24:8];

  // Integrate, clamp and clear when the pitch is past the tilt limit
  assign isum    = 22'(integ_q) + 22'(filt_q);
  assign ilim    = $signed({2'b00, integral_limit_q});
  assign pitch_x = 18'(pitch_q);
  assign tilt_x  = $signed({2'b00, tilt_limit_q});
  always_comb begin
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
    if ((pitch_x > tilt_x) || (pitch_x < -tilt_x)) begin
      integ_d = '0;
    end else begin
      integ_d = iclamp[20:0];
    end
  end

  // Filter and integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      integ_q <= '0;
    end else begin
      if (cmd_i.filt_en)  filt_q  <= filt_d;
      if (cmd_i.integ_en) integ_q <= integ_d;
    end
  end

  // Divide the drive sum by 4096 toward zero, then saturate to 32 bits
  assign dbias = acc_q + $signed({35'd0, {12{acc_q[46]}}});
  assign dquo  = dbias[46:12];
  always_comb begin
    if (!dquo[34] && (|dquo[33:31])) begin
      drive_d = {1'b0, {31{1'b1}}};
    end else if (dquo[34] && !(&dquo[33:31])) begin
      drive_d = {1'b1, 31'd0};
    end else begin
      drive_d = dquo[31:0];
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      drive_q     <= drive_d;
      filt_out_q  <= filt_q;
      integ_out_q <= integ_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign drive_value_o     = drive_q;
  assign filtered_error_o  = filt_out_q;
  assign integral_sum_o    = integ_out_q;

endmodule

@@ design/speed_pi_loop_with_lowpass_unit.sv @@
// Top level of the speed PI loop unit.
// Depends on spl_pkg, spl_if, spl_ctrl and spl_datapath.
//
// Speed PI loop with a first-order low-pass on the speed error. Each input
// item (left and right wheel speed, pitch) yields one result item: the drive
// value, the filtered error and the integrator after clamp and tilt clear.
// One item is worked at a time through a single shared 25x22 multiplier that
// a sequencer steps through four products; the next item can be taken in the
// same cycle as the finished result is loaded into the output register, so
// the unit takes no new item before the last one is through. The result
// sits in an output register; while it is not taken the unit finishes the
// next item and then waits. Registers: 0 speed gain, 1 integral gain
// (signed Q12), 2 filter alpha (Q0.8), 3 integral limit, 4 tilt limit; write
// them only while the unit is idle. Filter and integrator clear on reset.
module speed_pi_loop_with_lowpass_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spl_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [spl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  spl_in_if.sink                        in_i,
  spl_out_if.source                     out_o
);
  import spl_pkg::*;

  spl_cmd_t    cmd;
  spl_status_t status;

  // Sequencer
  spl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register
  spl_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .left_speed_i     (in_i.left_speed),
    .right_speed_i    (in_i.right_speed),
    .pitch_angle_i    (in_i.pitch_angle),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .drive_value_o    (out_o.drive_value),
    .filtered_error_o (out_o.filtered_error),
    .integral_sum_o   (out_o.integral_sum)
  );

endmodule

@@ design/spl_checker.sv @@
// Port checker of the speed PI loop unit and its bind to the top level.
// Depends on speed_pi_loop_with_lowpass_unit_macros.svh.
`include "speed_pi_loop_with_lowpass_unit_macros.svh"

module spl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] drive_value_i,
  input logic signed [20:0] integral_sum_i
);

  // An accepted item keeps the input closed for the next cycle
  `SPL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // The integrator never reaches the most negative 21-bit code
  `SPL_ASSERT_NOW(a_integ_range, clk_i, rst_ni, out_valid_i, integral_sum_i != 21'sh100000)

  // A stalled result stays valid
  `SPL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled result keeps its drive value
  `SPL_ASSERT_NEXT(a_drive_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(drive_value_i))

endmodule

bind speed_pi_loop_with_lowpass_unit spl_checker u_spl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .drive_value_i  (out_o.drive_value),
  .integral_sum_i (out_o.integral_sum)
);
